// ----- hw/rtl/nvp_pkg.sv -----
// Shared types and constants for the name-value pair parser.
// Used by nvp_core and name_value_pair_parser; no dependencies.
`default_nettype none

package nvp_pkg;

   localparam int BYTE_W = 8;
   // Width of the reported lengths and of the four-byte length accumulator.
   localparam int LEN_W  = 31;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_KEY     = 2'd0;
   localparam kind_type KIND_VALUE   = 2'd1;
   localparam kind_type KIND_LENGTHS = 2'd2;
   localparam kind_type KIND_STATUS  = 2'd3;

   typedef struct packed {
      logic              have;
      logic [BYTE_W-1:0] pair_byte;
      kind_type          kind;
      logic [LEN_W-1:0]  key_length;
      logic [LEN_W-1:0]  value_length;
      logic              field_end;
      logic              pair_end;
      logic              truncated;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/nvp_core.sv -----
// Parser state and per-byte decode for the name-value pair parser.
// Depends on nvp_pkg for the result struct and kind codes.
`default_nettype none

module nvp_core #(
   parameter int LENGTH_BITS = 31
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic [nvp_pkg::BYTE_W-1:0] in_byte,
   input  wire logic                      stream_last,
   output nvp_pkg::result_type            result
);

   typedef enum logic [2:0] {
      PH_KLEN = 3'd0,
      PH_VLEN = 3'd1,
      PH_KEY  = 3'd2,
      PH_VAL  = 3'd3
   } phase_type;

   localparam logic [31:0] LEN_LIMIT = (32'd1 << LENGTH_BITS) - 32'd1;

   phase_type                     phase_ff, phase_in;
   logic [1:0]                    cnt_ff, cnt_in;
   logic [nvp_pkg::LEN_W-1:0]     acc_ff, acc_in;
   logic [LENGTH_BITS-1:0]        hkl_ff, hkl_in;
   logic [LENGTH_BITS-1:0]        hvl_ff, hvl_in;
   logic [LENGTH_BITS-1:0]        rem_ff, rem_in;

   logic [LENGTH_BITS-1:0]        rem_dec;
   logic [nvp_pkg::LEN_W-1:0]     acc_shift;
   logic [nvp_pkg::LEN_W-1:0]     len;
   logic [LENGTH_BITS-1:0]        len_sat;
   logic                          done;
   logic                          mid_pair;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      hkl_in    = hkl_ff;
      hvl_in    = hvl_ff;
      rem_in    = rem_ff;
      result    = '0;
      result.kind = nvp_pkg::KIND_STATUS;
      done      = 1'b0;
      len       = '0;
      rem_dec   = (rem_ff != '0) ? rem_ff - LENGTH_BITS'(1) : '0;
      acc_shift = {acc_ff[nvp_pkg::LEN_W-9:0], in_byte};

      case (phase_ff)
         PH_KEY, PH_VAL: begin
            result.have      = 1'b1;
            result.pair_byte = in_byte;
            result.kind      = (phase_ff == PH_KEY) ? nvp_pkg::KIND_KEY : nvp_pkg::KIND_VALUE;
            rem_in           = rem_dec;
            if (rem_dec == '0) begin
               result.field_end = 1'b1;
               if (phase_ff == PH_KEY && hvl_ff != '0) begin
                  phase_in = PH_VAL;
                  rem_in   = hvl_ff;
               end else begin
                  result.pair_end = 1'b1;
                  phase_in        = PH_KLEN;
               end
            end
         end
         default: begin
            // length phases; unreachable codes behave as the key length phase
            if (cnt_ff == 2'd0) begin
               if (in_byte[7]) begin
                  acc_in = nvp_pkg::LEN_W'(in_byte[6:0]);
                  cnt_in = 2'd1;
               end else begin
                  len  = nvp_pkg::LEN_W'(in_byte);
                  done = 1'b1;
               end
            end else begin
               acc_in = acc_shift;
               if (cnt_ff == 2'd3) begin
                  len    = acc_shift;
                  acc_in = '0;
                  cnt_in = 2'd0;
                  done   = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 2'd1;
               end
            end
         end
      endcase

      if ({1'b0, len} > LEN_LIMIT)
         len_sat = LEN_LIMIT[LENGTH_BITS-1:0];
      else
         len_sat = len[LENGTH_BITS-1:0];

      if (done) begin
         if (phase_ff == PH_VLEN) begin
            hvl_in      = len_sat;
            result.have = 1'b1;
            result.kind = nvp_pkg::KIND_LENGTHS;
            if (hkl_ff != '0) begin
               phase_in = PH_KEY;
               rem_in   = hkl_ff;
            end else if (len_sat != '0) begin
               phase_in = PH_VAL;
               rem_in   = len_sat;
            end else begin
               result.pair_end = 1'b1;
               phase_in        = PH_KLEN;
            end
         end else begin
            hkl_in   = len_sat;
            phase_in = PH_VLEN;
         end
      end

      result.key_length   = nvp_pkg::LEN_W'(hkl_in);
      result.value_length = nvp_pkg::LEN_W'(hvl_in);

      mid_pair = !((phase_in == PH_KLEN || phase_in > PH_VAL) && cnt_in == 2'd0);
      if (stream_last) begin
         if (mid_pair) begin
            result.truncated = 1'b1;
            if (!result.have) begin
               result.have      = 1'b1;
               result.kind      = nvp_pkg::KIND_STATUS;
               result.pair_byte = '0;
            end
         end
         phase_in = PH_KLEN;
         cnt_in   = '0;
         acc_in   = '0;
         hkl_in   = '0;
         hvl_in   = '0;
         rem_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KLEN;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         hkl_ff   <= '0;
         hvl_ff   <= '0;
         rem_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         hkl_ff   <= hkl_in;
         hvl_ff   <= hvl_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/name_value_pair_parser.sv -----
// Name-value pair parser, top level: input register, decode core, result register.
// Depends on nvp_pkg and nvp_core.
//
// Usage:
//   req_* carries the parameter stream, one byte per item; req_tlast marks the
//   stream's last byte. Each pair is a key length, a value length (one byte, or
//   four big-endian bytes with the top bit set), then the key and value bytes.
//   rsp_* gives at most one item per input byte: a tagged key or value byte,
//   the decoded lengths once per pair, or a status item on a truncated stream.
//   rsp_tlast is high on the item that completes a pair.
// Timing:
//   An accepted byte is held in the input register and decoded from there
//   into the result register, whose contents drive rsp_*. One byte per cycle
//   is sustained while rsp_tready stays high; the parser state updates once
//   per decoded byte.
// Stalls and reset:
//   While rsp_tready is low with a result pending, the input register still
//   drains bytes that give no result, and refills behind a held result, so
//   req_tready falls only once both registers are full. Reset empties both
//   registers and returns the parser to the key length phase.
`default_nettype none

module name_value_pair_parser #(
   parameter int LENGTH_BITS = 31
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // stream_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [7:0] pair_byte, [38:8] key_length,
                                         // [69:39] value_length, [70] field_end,
                                         // [71] truncated
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // pair_end
);

   logic                        in_valid_ff;
   logic [nvp_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                        in_last_ff;
   logic                        rsp_valid_ff;
   nvp_pkg::result_type         rsp_ff;
   nvp_pkg::result_type         result;
   logic                        advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready || !result.have);
   assign req_tready = !in_valid_ff || advance;

   nvp_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .in_byte     (in_byte_ff),
      .stream_last (in_last_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready)
            in_valid_ff <= req_tvalid;
         if (advance && result.have)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && result.have)
         rsp_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.truncated, rsp_ff.field_end, rsp_ff.value_length,
                        rsp_ff.key_length, rsp_ff.pair_byte};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.pair_end;

endmodule

`default_nettype wire

// ----- sim/tb_name_value_pair_parser.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for name_value_pair_parser: directed and random parameter streams,
// a byte-level predictor of the pair decode, and an in-order check of every result item.
// Depends on nvp_pkg and the parser RTL.

module tb_name_value_pair_parser;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 550;
   localparam int MAX_REPORTS  = 10;
   localparam int LEN_W        = nvp_pkg::LEN_W;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef enum logic [2:0] {
      PH_KEY_LEN,
      PH_VALUE_LEN,
      PH_KEY_BYTES,
      PH_VALUE_BYTES
   } parse_phase_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] in_byte
   logic        req_tlast = 1'b0; // stream_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [7:0] pair_byte, [38:8] key_length,
                                  // [69:39] value_length, [70] field_end, [71] truncated
   logic [1:0]  rsp_tuser;        // [1:0] kind
   logic        rsp_tlast;        // pair_end

   name_value_pair_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   stream_byte_type     pending_bytes[$];
   nvp_pkg::result_type expected_results[$];
   logic [7:0]          pair_buf[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        req_fire = 1'b0;
   int          bytes_queued = 0;
   int          bytes_accepted = 0;
   int          results_checked = 0;
   int          pairs_closed = 0;
   int          truncations = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   // Parser state as the predictor sees it
   parse_phase_type  ph;
   logic [1:0]       len_bytes_seen;
   logic [LEN_W-1:0] len_acc;
   logic [LEN_W-1:0] key_len_held;
   logic [LEN_W-1:0] value_len_held;
   logic [LEN_W-1:0] field_left;

   task automatic clear_parser();
      ph             = PH_KEY_LEN;
      len_bytes_seen = '0;
      len_acc        = '0;
      key_len_held   = '0;
      value_len_held = '0;
      field_left     = '0;
   endtask

   // At 31 bits the saturation limit equals the full accumulator range.
   task automatic parse_stream_byte(input logic [7:0] b, input logic last,
                                    output bit got, output nvp_pkg::result_type r);
      logic [LEN_W-1:0] len;
      bit               done;
      got  = 1'b0;
      done = 1'b0;
      len  = '0;
      r    = '0;
      r.have = 1'b1;
      r.kind = nvp_pkg::KIND_STATUS;
      if (ph == PH_KEY_BYTES || ph == PH_VALUE_BYTES) begin
         got = 1'b1;
         r.pair_byte = b;
         r.kind = (ph == PH_KEY_BYTES) ? nvp_pkg::KIND_KEY : nvp_pkg::KIND_VALUE;
         if (field_left != 0) field_left--;
         if (field_left == 0) begin
            r.field_end = 1'b1;
            if (ph == PH_KEY_BYTES && value_len_held != 0) begin
               ph = PH_VALUE_BYTES;
               field_left = value_len_held;
            end else begin
               r.pair_end = 1'b1;
               ph = PH_KEY_LEN;
            end
         end
      end else begin
         if (len_bytes_seen == 0) begin
            if (b[7]) begin
               len_acc = LEN_W'(b[6:0]);
               len_bytes_seen = 2'd1;
            end else begin
               len = LEN_W'(b);
               done = 1'b1;
            end
         end else begin
            len_acc = {len_acc[LEN_W-9:0], b};
            if (len_bytes_seen == 2'd3) begin
               len = len_acc;
               len_acc = '0;
               len_bytes_seen = '0;
               done = 1'b1;
            end else begin
               len_bytes_seen++;
            end
         end
         if (done) begin
            if (ph == PH_VALUE_LEN) begin
               value_len_held = len;
               got = 1'b1;
               r.kind = nvp_pkg::KIND_LENGTHS;
               if (key_len_held != 0) begin
                  ph = PH_KEY_BYTES;
                  field_left = key_len_held;
               end else if (value_len_held != 0) begin
                  ph = PH_VALUE_BYTES;
                  field_left = value_len_held;
               end else begin
                  r.pair_end = 1'b1;
                  ph = PH_KEY_LEN;
               end
            end else begin
               key_len_held = len;
               ph = PH_VALUE_LEN;
            end
         end
      end
      r.key_length   = key_len_held;
      r.value_length = value_len_held;
      if (last) begin
         // anything but a clean pair boundary is a cut-off pair
         if (ph != PH_KEY_LEN || len_bytes_seen != 0) begin
            r.truncated = 1'b1;
            got = 1'b1;
         end
         clear_parser();
      end
   endtask

   task automatic report_mismatch(input string what, input nvp_pkg::result_type exp,
                                  input nvp_pkg::result_type act);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t %s: exp byte %02h kind %0d klen %0d vlen %0d fe %0b pe %0b tr %0b",
                  $time, what, exp.pair_byte, exp.kind, exp.key_length, exp.value_length,
                  exp.field_end, exp.pair_end, exp.truncated);
         $display("   act byte %02h kind %0d klen %0d vlen %0d fe %0b pe %0b tr %0b",
                  act.pair_byte, act.kind, act.key_length, act.value_length,
                  act.field_end, act.pair_end, act.truncated);
      end
   endtask

   // Driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes[0].data;
               req_tlast  <= pending_bytes[0].last;
               void'(pending_bytes.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: checks results and predicts on accepted bytes at the rising edge
   always @(posedge clock) begin : monitor
      bit                  got;
      nvp_pkg::result_type exp;
      nvp_pkg::result_type act;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            act.have         = 1'b1;
            act.pair_byte    = rsp_tdata[7:0];
            act.key_length   = rsp_tdata[38:8];
            act.value_length = rsp_tdata[69:39];
            act.field_end    = rsp_tdata[70];
            act.truncated    = rsp_tdata[71];
            act.kind         = rsp_tuser;
            act.pair_end     = rsp_tlast;
            results_checked++;
            if (act.pair_end) pairs_closed++;
            if (act.truncated) truncations++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", '0, act);
            end else begin
               exp = expected_results.pop_front();
               if (act !== exp) report_mismatch("result mismatch", exp, act);
            end
         end
         if (req_tvalid && req_tready) begin
            bytes_accepted++;
            parse_stream_byte(req_tdata, req_tlast, got, exp);
            if (got) expected_results.push_back(exp);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_name_value_pair_parser NOT OK");
         $finish;
      end
   end

   // ---- stimulus ----

   task automatic queue_byte(input logic [7:0] data, input logic last);
      stream_byte_type sb;
      sb.data = data;
      sb.last = last;
      pending_bytes.push_back(sb);
      bytes_queued++;
   endtask

   task automatic put_length(input logic [LEN_W-1:0] len, input bit four_byte);
      if (four_byte || len > 127) begin
         pair_buf.push_back({1'b1, len[30:24]});
         pair_buf.push_back(len[23:16]);
         pair_buf.push_back(len[15:8]);
         pair_buf.push_back(len[7:0]);
      end else begin
         pair_buf.push_back(len[7:0]);
      end
   endtask

   // Header plus key and value bytes, data capped at data_cap bytes
   task automatic build_pair(input logic [LEN_W-1:0] klen, input logic [LEN_W-1:0] vlen,
                             input bit long_k, input bit long_v, input longint data_cap);
      longint total;
      pair_buf.delete();
      put_length(klen, long_k);
      put_length(vlen, long_v);
      total = longint'(klen) + longint'(vlen);
      if (total > data_cap) total = data_cap;
      for (longint i = 0; i < total; i++) pair_buf.push_back(8'($urandom_range(255)));
   endtask

   // cut < 0: whole pair; else stop at byte cut and end the stream there
   task automatic send_pair(input int cut, input bit end_stream);
      int stop;
      stop = (cut < 0) ? pair_buf.size() - 1 : cut;
      for (int i = 0; i <= stop; i++)
         queue_byte(pair_buf[i], (i == stop) && (cut >= 0 || end_stream));
   endtask

   function automatic logic [LEN_W-1:0] rand_len();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 25) return '0;
      if (sel < 97) return LEN_W'($urandom_range(1, 12));
      return LEN_W'($urandom_range(128, 200));
   endfunction

   task automatic random_traffic(input int count);
      int               target;
      int unsigned      sel;
      int               npairs;
      int               n;
      bit               end_it;
      bit               huge;
      logic [LEN_W-1:0] klen;
      logic [LEN_W-1:0] vlen;
      target = bytes_queued + count;
      while (bytes_queued < target) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            // well-formed stream of a few pairs, usually closed by tlast
            npairs = $urandom_range(1, 4);
            end_it = ($urandom_range(9) != 0);
            for (int p = 0; p < npairs; p++) begin
               build_pair(rand_len(), rand_len(), $urandom_range(3) == 0,
                          $urandom_range(3) == 0, 64'd1000);
               send_pair(-1, end_it && (p == npairs - 1));
            end
         end else if (sel < 88) begin
            // pair cut off anywhere, possibly with huge lengths
            huge = ($urandom_range(3) == 0);
            klen = huge ? LEN_W'($urandom) : rand_len();
            vlen = huge ? (($urandom_range(1) == 0) ? LEN_MAX : LEN_W'($urandom)) : rand_len();
            build_pair(klen, vlen, $urandom_range(1) == 0, $urandom_range(1) == 0, 64'd16);
            send_pair($urandom_range(pair_buf.size() - 1), 1'b1);
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(255)), i == n - 1);
         end
      end
   endtask

   initial begin
      clear_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase_idx = 0; phase_idx < 3; phase_idx++) begin
         send_idle_pct = (phase_idx == 0) ? 17 : (phase_idx == 1) ? 75 : 0;
         recv_idle_pct = (phase_idx == 0) ? 75 : (phase_idx == 1) ? 17 : 0;
         if (phase_idx == 0) begin
            // one-byte lengths, extreme data bytes
            build_pair(1, 1, 1'b0, 1'b0, 64'd1000);
            pair_buf[2] = 8'h00;
            pair_buf[3] = 8'hFF;
            send_pair(-1, 1'b1);
            // both lengths zero
            build_pair(0, 0, 1'b0, 1'b0, 64'd1000);
            send_pair(-1, 1'b1);
            // empty key
            build_pair(0, 1, 1'b0, 1'b0, 64'd1000);
            send_pair(-1, 1'b1);
            // empty value
            build_pair(1, 0, 1'b0, 1'b0, 64'd1000);
            send_pair(-1, 1'b1);
            // four-byte encodings of small lengths
            build_pair(1, 0, 1'b1, 1'b1, 64'd1000);
            send_pair(-1, 1'b1);
            // largest value length, stream cut after one value byte
            build_pair(0, LEN_MAX, 1'b0, 1'b1, 64'd1);
            send_pair(pair_buf.size() - 1, 1'b1);
         end
         random_traffic(PHASE_ITEMS);
         // hold the sender until everything predicted has come back
         while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0)
            @(negedge clock);
         repeat (DRAIN_CYCLES) @(negedge clock);
      end

      $display("Sent %0d stream bytes over three stall patterns; checked %0d results",
               bytes_accepted, results_checked);
      $display("including %0d completed pairs and %0d truncated streams",
               pairs_closed, truncations);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb_name_value_pair_parser OK");
      end else begin
         $display("tb_name_value_pair_parser NOT OK");
      end
      $finish;
   end

endmodule
